/* rtl/salc_pkg.sv */
package salc_pkg;

    localparam int TAG_W  = 64;
    localparam int ADDR_W = 64;

    // access kinds
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_STORE  = 2'd1;
    localparam logic [1:0] FUNC_MODIFY = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
    } t_cache_req;

    typedef struct packed {
        logic hit;
        logic evicted;
        logic second_hit;
    } t_cache_rsp;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

/* rtl/salc_ram.sv */
module salc_ram import salc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/set_assoc_lru_cache_tags_top.sv */
// The set row is read at accept; compare, row write-back and result capture follow in lookup.
// A new item is taken only in the idle state, after the previous lookup has finished; the set
// row is read, then written back. A result held in the output register stalls the next lookup.
// Reset (synchronous, active low) clears control and config, then a clearing pass writes
// every set row, one per cycle, before the first item is taken.
// Configuration writes are taken at any time, also during the clearing pass.
module set_assoc_lru_cache_tags_top import salc_pkg::*; #(
    parameter int MAX_SET_BITS = 8,
    parameter int WAYS         = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_cache_req i_in,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cache_rsp o_out,
    // config write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data
);

    // Per-way recency is kept as a rank (0 = oldest, WAYS-1 = newest). The ranks of a set
    // always form a permutation; touching a way lifts it to the top and shifts the ones
    // above it down, so the order among valid ways equals the order of access stamps.
    localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH = 1 << MAX_SET_BITS;
    localparam int NW_W  = $clog2(WAYS + 1);
    localparam int ROW_W = WAYS * (1 + RW + TAG_W);

    // config
    logic [3:0]      r_sb;
    logic [3:0]      n_sb;
    logic [5:0]      r_ob;
    logic [NW_W-1:0] r_nw;
    logic [NW_W-1:0] n_nw;

    // control
    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_clr_idx;
    logic            clr_last;
    logic            finish;

    // lookup stage
    logic [1:0]       r_func;
    logic [TAG_W-1:0] r_tag;
    logic [AW-1:0]    r_set;

    // output register
    logic       r_out_valid;
    t_cache_rsp r_out;
    t_cache_rsp n_out;

    // request decode
    logic [ADDR_W-1:0] addr_sh;
    logic [AW-1:0]     set_mask;
    logic [AW-1:0]     req_set;
    logic [6:0]        split_sum;
    logic [TAG_W-1:0]  req_tag;

    // memory
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    logic [WAYS-1:0]            rd_valid;
    logic [WAYS-1:0][RW-1:0]    rd_rank;
    logic [WAYS-1:0][TAG_W-1:0] rd_tag;
    logic [WAYS-1:0]            wr_valid;
    logic [WAYS-1:0][RW-1:0]    wr_rank;
    logic [WAYS-1:0][TAG_W-1:0] wr_tag;
    logic [WAYS-1:0][RW-1:0]    clr_rank;

    // way selection
    logic          hit_any;
    logic [RW-1:0] hit_way;
    logic          empty_any;
    logic [RW-1:0] empty_way;
    logic [RW-1:0] vic_way;
    logic [RW-1:0] sel_way;
    logic [RW-1:0] sel_rank;

    // ---------------------------------------------------------------- config
    always_comb begin
        n_sb = (int'(i_cfg_data[3:0]) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : i_cfg_data[3:0];
        if (i_cfg_data[3:0] == 4'd0) begin
            n_nw = NW_W'(1);
        end else if (int'(i_cfg_data[3:0]) > WAYS) begin
            n_nw = NW_W'(WAYS);
        end else begin
            n_nw = NW_W'(i_cfg_data[3:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb <= '0;
            r_ob <= '0;
            r_nw <= NW_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_BITS:    r_sb <= n_sb;
                CFG_OFFSET_BITS: r_ob <= i_cfg_data;
                CFG_WAYS:        r_nw <= n_nw;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- decode
    // set = (address >> offset) masked to the set bits; tag = address >> (offset + set bits)
    always_comb begin
        addr_sh = i_in.address >> r_ob;
        for (int b = 0; b < AW; b++) begin
            set_mask[b] = (b < int'(r_sb));
        end
        req_set   = addr_sh[AW-1:0] & set_mask;
        split_sum = {1'b0, r_ob} + {3'b000, r_sb};
        req_tag   = split_sum[6] ? '0 : (i_in.address >> split_sum[5:0]);
    end

    // ---------------------------------------------------------------- control
    assign clr_last = (r_clr_idx == AW'(DEPTH - 1));
    assign finish   = (r_state == ST_LOOKUP) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (clr_last) begin
                n_state = ST_IDLE;
            end
            ST_IDLE:   if (i_in_valid) begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: if (finish) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_set;
        ram_raddr  = r_set;
        ram_wdata  = {wr_tag, wr_rank, wr_valid};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = {{(WAYS * TAG_W){1'b0}}, clr_rank, {WAYS{1'b0}}};
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_raddr  = req_set;
            end
            ST_LOOKUP: begin
                // read address held at r_set so the row stays put while stalled
                ram_we = finish && (r_func != FUNC_NONE);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
        end
    end

    // capture the decoded request on accept
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func <= i_in.func;
            r_tag  <= req_tag;
            r_set  <= req_set;
        end
    end

    // ---------------------------------------------------------------- set memory
    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign {rd_tag, rd_rank, rd_valid} = ram_rdata;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            clr_rank[w] = RW'(w);
        end
    end

    // ---------------------------------------------------------------- lookup
    always_comb begin
        hit_any   = 1'b0;
        hit_way   = '0;
        empty_any = 1'b0;
        empty_way = '0;
        vic_way   = '0;
        // lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((w < int'(r_nw)) && rd_valid[w] && (rd_tag[w] == r_tag)) begin
                hit_any = 1'b1;
                hit_way = RW'(w);
            end
        end
        // highest free way is filled
        for (int w = 0; w < WAYS; w++) begin
            if ((w < int'(r_nw)) && !rd_valid[w]) begin
                empty_any = 1'b1;
                empty_way = RW'(w);
            end
        end
        // oldest way in use; ranks are distinct
        for (int w = 1; w < WAYS; w++) begin
            if ((w < int'(r_nw)) && (rd_rank[w] < rd_rank[vic_way])) begin
                vic_way = RW'(w);
            end
        end
        sel_way  = hit_any ? hit_way : (empty_any ? empty_way : vic_way);
        sel_rank = rd_rank[sel_way];
    end

    always_comb begin
        wr_valid = rd_valid;
        wr_tag   = rd_tag;
        for (int w = 0; w < WAYS; w++) begin
            if (RW'(w) == sel_way) begin
                wr_rank[w] = RW'(WAYS - 1);
            end else if (rd_rank[w] > sel_rank) begin
                wr_rank[w] = rd_rank[w] - RW'(1);
            end else begin
                wr_rank[w] = rd_rank[w];
            end
        end
        wr_valid[sel_way] = 1'b1;
        wr_tag[sel_way]   = r_tag;
    end

    always_comb begin
        n_out.hit        = hit_any && (r_func != FUNC_NONE);
        n_out.evicted    = !hit_any && !empty_any && (r_func != FUNC_NONE);
        n_out.second_hit = (r_func == FUNC_MODIFY);
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------- checks
    a_we_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_LOOKUP))
        else $error("set row written outside clear or lookup");

    a_out_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_LOOKUP))
        else $error("result appeared without a lookup");

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_LOOKUP))
        else $error("accepted item did not enter lookup");

    a_stall_holds_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP && !finish) |=> $stable(ram_raddr) && (r_state == ST_LOOKUP))
        else $error("stalled lookup lost its set row");

endmodule

/* sim/set_assoc_lru_cache_tags_top_test.sv */
module set_assoc_lru_cache_tags_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import salc_pkg::*;

    localparam int MAX_SET_BITS = 8;
    localparam int WAYS         = 8;
    localparam int N_LINES      = (1 << MAX_SET_BITS) * WAYS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    // receiver stall styles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_cache_req in_item  = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_cache_rsp out_item;
    logic       cfg_we   = 1'b0;
    logic [1:0] cfg_idx  = CFG_SET_BITS;
    logic [5:0] cfg_data = '0;

    set_assoc_lru_cache_tags_top #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .WAYS        (WAYS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Tag store predictor: own copy of lines, LRU stamps and config.
    // Line (set, way) sits at set*WAYS + way, as in the block.
    // ------------------------------------------------------------------
    bit          line_ok    [N_LINES];
    bit   [63:0] line_tag   [N_LINES];
    bit   [63:0] line_stamp [N_LINES];
    bit   [63:0] access_cnt;

    logic [3:0]  m_set_bits = 4'd0;
    logic [5:0]  m_off_bits = 6'd0;
    logic [3:0]  m_ways     = 4'd1;

    t_cache_req  pending_items [$];   // items waiting for the driver
    t_cache_rsp  expected_rsp  [$];   // predicted results, oldest first
    logic [63:0] tag_pool [16];

    int errors    = 0;
    int cycle_cnt = 0;

    // set bits saturate at the built maximum
    function automatic int eff_set_bits();
        return (m_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(m_set_bits);
    endfunction

    // 0 acts as one way, anything above the built count as all ways
    function automatic int eff_ways();
        if (m_ways < 1) return 1;
        if (m_ways > WAYS) return WAYS;
        return int'(m_ways);
    endfunction

    function automatic t_cache_rsp cache_lookup(t_cache_req req);
        t_cache_rsp  rsp;
        int          sb, ob, nw, base, best, empty_way;
        bit          have_empty, found;
        logic [63:0] set_v, tg;
        rsp = '0;
        if (req.func == FUNC_NONE) return rsp;   // unused code: no state change
        sb = eff_set_bits();
        ob = int'(m_off_bits);
        nw = eff_ways();
        set_v = (req.address >> ob) & ((64'd1 << sb) - 64'd1);
        // wide split leaves nothing for the tag
        tg = (ob + sb >= 64) ? 64'd0 : (req.address >> (ob + sb));
        base = int'(set_v) * WAYS;
        access_cnt = access_cnt + 64'd1;
        found = 0;
        have_empty = 0;
        empty_way = 0;
        for (int w = 0; w < nw; w++) begin
            if (!found) begin
                if (line_ok[base + w] && line_tag[base + w] == tg) begin
                    line_stamp[base + w] = access_cnt;
                    found = 1;
                end else if (!line_ok[base + w]) begin
                    have_empty = 1;
                    empty_way = w;      // last one seen wins: highest free way
                end
            end
        end
        if (found) begin
            rsp.hit = 1'b1;
        end else begin
            if (have_empty) begin
                best = empty_way;
            end else begin
                // first way holding the oldest stamp
                best = 0;
                for (int w = 1; w < nw; w++) begin
                    if (line_stamp[base + w] < line_stamp[base + best]) best = w;
                end
                rsp.evicted = 1'b1;
            end
            line_ok[base + best]    = 1'b1;
            line_tag[base + best]   = tg;
            line_stamp[base + best] = access_cnt;
        end
        // store half of a modify always hits and changes nothing
        rsp.second_hit = (req.func == FUNC_MODIFY);
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps, fed from pending_items.
    // The result is predicted at the edge the item is taken.
    // ------------------------------------------------------------------
    int   burst_left = 0;
    int   gap_left   = 0;
    logic no_gaps    = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) expected_rsp.push_back(cache_lookup(in_item));
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_items.pop_front();
                    if (burst_left > 0) burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                        if (no_gaps || $urandom_range(0, 3) == 0) gap_left = 0;
                        else gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and receiver: checks each taken result against the oldest
    // prediction, and drives ready on a stall pattern of its own.
    // A bump of hold_token asks for one long hold-off.
    // ------------------------------------------------------------------
    int       hold_token = 0;
    int       hold_seen  = 0;
    int       hold_left  = 0;
    int       mode_left  = 0;
    int       pat_pos    = 0;
    t_rx_mode rx_mode    = RX_OPEN;
    logic [7:0] rx_pat   = 8'hFF;

    task automatic report_field(string name, logic want, logic got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk) begin
        t_cache_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t ns: result with no item pending, expected none, got %b",
                         $time, out_item);
                errors = errors + 1;
            end else begin
                want = expected_rsp.pop_front();
                report_field("hit", want.hit, out_item.hit);
                report_field("evicted", want.evicted, out_item.evicted);
                report_field("second_hit", want.second_hit, out_item.second_hit);
            end
        end

        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_mode = RX_OPEN;
                    1: rx_mode = RX_COIN;
                    2: rx_mode = RX_SPARSE;
                    default: rx_mode = RX_PATTERN;
                endcase
                mode_left = $urandom_range(10, 80);
                rx_pat = 8'($urandom) | 8'h01;   // never all-stall
            end
            mode_left = mode_left - 1;
            pat_pos = (pat_pos + 1) % 8;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= rx_pat[pat_pos];
            endcase
        end
    end

    // run-away guard
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(logic [1:0] func, logic [63:0] addr);
        t_cache_req it;
        it.func = func;
        it.address = addr;
        pending_items.push_back(it);
    endtask

    // Mostly addresses built from a small tag pool over four sets, so that
    // sets fill, hit and evict; the rest fully random. A few unused codes.
    function automatic t_cache_req rand_item();
        t_cache_req  it;
        int          sb, ob, pool_n;
        logic [63:0] set_v, off_v, tag_v;
        logic [1:0]  kinds [3];
        kinds = '{FUNC_LOAD, FUNC_STORE, FUNC_MODIFY};
        sb = eff_set_bits();
        ob = int'(m_off_bits);
        pool_n = eff_ways() + 2;
        it.func = ($urandom_range(0, 15) == 0) ? FUNC_NONE : kinds[$urandom_range(0, 2)];
        if ($urandom_range(0, 9) == 0) begin
            it.address = {$urandom, $urandom};
        end else begin
            tag_v = tag_pool[$urandom_range(0, pool_n - 1)];
            set_v = 64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1);
            off_v = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
            it.address = ((ob + sb >= 64) ? 64'd0 : (tag_v << (ob + sb)))
                       | (set_v << ob) | off_v;
        end
        return it;
    endfunction

    // Three back-to-back register writes; only called while idle.
    task automatic set_config(logic [5:0] sb, logic [5:0] ob, logic [5:0] nw);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SET_BITS;
        cfg_data <= sb;
        @(posedge clk);
        cfg_idx  <= CFG_OFFSET_BITS;
        cfg_data <= ob;
        @(posedge clk);
        cfg_idx  <= CFG_WAYS;
        cfg_data <= nw;
        @(posedge clk);
        cfg_we   <= 1'b0;
        m_set_bits = sb[3:0];
        m_off_bits = ob;
        m_ways     = nw[3:0];
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        logic [5:0] sb, ob, nw;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: one set, no offset, one way
        add_item(FUNC_LOAD,   64'h0);                   // miss into empty way
        add_item(FUNC_LOAD,   64'h0);                   // hit
        add_item(FUNC_LOAD,   64'hFFFF_FFFF_FFFF_FFFF); // miss, evict
        add_item(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF); // hit plus second hit
        add_item(FUNC_NONE,   64'h0);                   // unused code
        add_item(FUNC_STORE,  64'h0);                   // store takes load path
        add_item(FUNC_MODIFY, 64'h5555_5555_5555_5555); // modify that misses
        add_item(FUNC_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
        wait_idle();

        // set bits above max saturate, ways 0 acts as 1, split reaches 64
        set_config(6'h3F, 6'd56, 6'd0);
        add_item(FUNC_LOAD,   64'h0);
        add_item(FUNC_LOAD,   64'hFF00_0000_0000_0000);
        add_item(FUNC_LOAD,   64'h0100_0000_0000_0000);
        add_item(FUNC_MODIFY, 64'hFF12_3456_789A_BCDE); // tag 0 again: hit
        add_item(FUNC_STORE,  64'h00FF_FFFF_FFFF_FFFF);
        add_item(FUNC_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
        wait_idle();

        // ways above built count act as all ways; overflow one set, LRU order
        set_config(6'd2, 6'd4, 6'h39);
        for (int t = 1; t <= 9; t++) add_item(FUNC_LOAD, 64'(t) << 6);
        add_item(FUNC_LOAD,   64'd1 << 6);
        add_item(FUNC_MODIFY, 64'd2 << 6);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin sb = 6'd8;  ob = 6'd0;  nw = 6'd8; end
                1: begin sb = 6'd0;  ob = 6'd63; nw = 6'd1; end
                2: begin sb = 6'd8;  ob = 6'd56; nw = 6'd8; end
                3: begin sb = 6'd3;  ob = 6'd2;  nw = 6'd8; end
                default: begin
                    sb = 6'($urandom_range(0, 63));
                    ob = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 12));
                    nw = 6'($urandom_range(0, 63));
                end
            endcase
            set_config(sb, ob, nw);
            for (int i = 0; i < 16; i++) tag_pool[i] = {$urandom, $urandom};
            // one phase back to back with a long receiver hold-off, so the
            // block backs up and drops in_ready while items keep coming
            no_gaps <= (p == 3);
            for (int i = 0; i < 75; i++) pending_items.push_back(rand_item());
            if (p == 3) hold_token <= hold_token + 1;
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* set_assoc_lru_cache_tags_top.f */
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/set_assoc_lru_cache_tags_top.sv
sim/set_assoc_lru_cache_tags_top_test.sv
